[rtl/can_frame_pool_accumulator_top_assert.svh]
// Assertion macros for the CAN frame pool accumulator.
`ifndef CAN_FRAME_POOL_ACCUMULATOR_TOP_ASSERT_SVH
`define CAN_FRAME_POOL_ACCUMULATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CFPA_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define CFPA_ASSERT_NEXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("assertion failed");
`else
`define CFPA_ASSERT_IMPL(lbl, clk, rstn, prop)
`define CFPA_ASSERT_NEXT(lbl, clk, rstn, a, b)
`endif
`endif

[rtl/cfpa_pkg.sv]
// ----------------------------------------------------------------------------
// CFPA package
// Codes and types shared by the CAN frame pool accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package cfpa_pkg;
  localparam logic [1:0] KIND_FRAME = 2'd0;
  localparam logic [1:0] KIND_TICK  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  localparam logic [1:0] OUT_FWD  = 2'd0;
  localparam logic [1:0] OUT_REL  = 2'd1;
  localparam logic [1:0] OUT_DROP = 2'd2;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [1:0]  pool_index;
    logic [10:0] frame_id;
    logic [3:0]  frame_dlc;
    logic [63:0] frame_data;
    logic [31:0] wait_ticks;
    logic        pool_end;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] can_id;
    logic [3:0]  dlc;
    logic [63:0] payload;
    logic [2:0]  map_pool;
    logic [15:0] map_holdup;
  } req_t;
endpackage
`default_nettype wire

[rtl/cfpa_if.sv]
// ----------------------------------------------------------------------------
// CFPA channel interface
// Valid/ready channel carrying one payload of parameter type.
// ----------------------------------------------------------------------------
`default_nettype none
interface cfpa_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/cfpa_deadline.sv]
// ----------------------------------------------------------------------------
// CFPA deadline unit
// Shared 32-bit subtract unit used for time left, deadline due and wait.
// ----------------------------------------------------------------------------
`default_nettype none
module cfpa_deadline (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] diff_o
);
  assign diff_o = a_i - b_i;
endmodule
`default_nettype wire

[rtl/can_frame_pool_accumulator_top.sv]
// ----------------------------------------------------------------------------
// CAN frame pool accumulator
// Maps frames to pools by ID, holds them and flushes pools at deadlines.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// req      in   kind, can_id, dlc, payload, map_pool, map_holdup
// res      out  out_kind, pool_index, frame_id, frame_dlc, frame_data, ...
// A table write is accepted and then applied; a frame is accepted, then goes
// through table read, time left and store. A tick is accepted and decoded,
// then each pool is checked in turn, and a due pool's frames are walked out
// of the slot memory one at a time by one subtractor.
// After reset the pool map is cleared by a pass over all 2^ID_BITS IDs,
// during which no request is taken. A stalled result holds the sequencer.
`default_nettype none
module can_frame_pool_accumulator_top #(
  parameter int NUM_POOLS  = 4,
  parameter int POOL_DEPTH = 16,
  parameter int ID_BITS    = 11
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cfpa_if.sink     req,
  cfpa_if.source   res
);
  import cfpa_pkg::*;
`include "can_frame_pool_accumulator_top_assert.svh"

  localparam int IdCount = 1 << ID_BITS;
  localparam int PB      = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int DB      = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int FB      = $clog2(POOL_DEPTH + 1);
  localparam int SB      = PB + DB;
  localparam int SlotCount = 1 << SB;

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001, S_IDLE = 10'b0000000010,
    S_LOOK = 10'b0000000100, S_FRM  = 10'b0000001000,
    S_STO  = 10'b0000010000, S_PCHK = 10'b0000100000,
    S_SRD  = 10'b0001000000, S_SOUT = 10'b0010000000,
    S_OUT  = 10'b0100000000, S_TNXT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  req_t   r_q;
  logic [ID_BITS-1:0] clr_q;
  logic [31:0] now_q;
  logic [31:0] dl_q [NUM_POOLS];
  logic [FB-1:0] fill_q [NUM_POOLS];
  logic [PB-1:0] p_q;
  logic [DB-1:0] i_q;
  res_t out_q;
  logic out_v_q;

  // Table memories.
  logic [2:0]  map_mem [IdCount];
  logic [15:0] hold_mem [IdCount];
  logic [2:0]  map_rd_q;
  logic [15:0] hold_rd_q;

  // Slot memories, addressed by pool and position within the pool.
  logic [10:0] sid_mem [SlotCount];
  logic [3:0]  sdlc_mem [SlotCount];
  logic [63:0] sdat_mem [SlotCount];
  logic [31:0] sarr_mem [SlotCount];
  logic [10:0] sid_q;
  logic [3:0]  sdlc_q;
  logic [63:0] sdat_q;
  logic [31:0] sarr_q;

  logic [ID_BITS-1:0] id;
  assign id = ID_BITS'(r_q.can_id);

  logic [PB-1:0] mp;
  assign mp = PB'(map_rd_q - 3'd1);
  logic [SB-1:0] rd_slot;
  assign rd_slot = {p_q, i_q};
  logic [SB-1:0] wr_slot;
  assign wr_slot = {mp, DB'(fill_q[mp])};

  // Shared subtractor operand selection.
  logic [31:0] sa, sb, diff;
  always_comb begin
    unique case (state_q)
      S_FRM:   begin sa = dl_q[mp]; sb = now_q; end
      S_PCHK:  begin sa = now_q;    sb = dl_q[p_q]; end
      default: begin sa = now_q;    sb = sarr_q; end
    endcase
  end
  cfpa_deadline u_sub (.a_i(sa), .b_i(sb), .diff_o(diff));

  logic due_pool;
  assign due_pool = (fill_q[p_q] != '0) && !diff[31];
  logic last_pool;
  assign last_pool = (32'(p_q) == NUM_POOLS - 1);

  // Remaining pools due? Not found by scanning ahead: the walk holds one result
  // back, and last is set on it when the walk ends at the last pool.
  logic pend_v_q;
  res_t pend_q;

  assign req.ready = (state_q == S_IDLE) && !out_v_q && !pend_v_q;
  assign res.valid = out_v_q;
  assign res.data  = out_q;

  logic [FB-1:0] cnt;
  assign cnt = fill_q[p_q];

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLR) map_mem[clr_q] <= 3'd0;
    else if (state_q == S_LOOK && r_q.kind == KIND_WRITE) begin
      map_mem[id]  <= (32'(r_q.map_pool) > NUM_POOLS) ? 3'd0 : r_q.map_pool;
      hold_mem[id] <= r_q.map_holdup;
    end
    map_rd_q  <= map_mem[id];
    hold_rd_q <= hold_mem[id];
    if (state_q == S_STO) begin
      sid_mem[wr_slot]  <= r_q.can_id;
      sdlc_mem[wr_slot] <= r_q.dlc;
      sdat_mem[wr_slot] <= r_q.payload;
      sarr_mem[wr_slot] <= now_q;
    end
    sid_q  <= sid_mem[rd_slot];
    sdlc_q <= sdlc_mem[rd_slot];
    sdat_q <= sdat_mem[rd_slot];
    sarr_q <= sarr_mem[rd_slot];
    if (req.valid && req.ready) r_q <= req.data;
  end

  logic out_free;
  assign out_free = !out_v_q || res.ready;
  logic [31:0] left_q;

  // A frame gives a result at once when it is forwarded or dropped.
  logic frm_out;
  assign frm_out = (map_rd_q == 3'd0) || (32'(map_rd_q) > NUM_POOLS) ||
                   (32'(fill_q[mp]) >= POOL_DEPTH);

  // The output register is loaded with a new result in this cycle.
  logic out_set;
  assign out_set = (state_q == S_FRM && frm_out) ||
                   (state_q == S_SOUT && pend_v_q && out_free) ||
                   (state_q == S_TNXT && last_pool && pend_v_q && out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      now_q    <= '0;
      out_v_q  <= 1'b0;
      out_q    <= '0;
      pend_v_q <= 1'b0;
      pend_q   <= '0;
      left_q   <= '0;
      p_q      <= '0;
      i_q      <= '0;
      for (int k = 0; k < NUM_POOLS; k++) begin
        fill_q[k] <= '0;
        dl_q[k]   <= '0;
      end
    end else begin
      out_v_q <= out_set || (out_v_q && !res.ready);
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ID_BITS'(IdCount - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) state_q <= S_LOOK;
        end
        S_LOOK: begin
          priority case (r_q.kind)
            KIND_FRAME: state_q <= S_FRM;
            KIND_TICK: begin
              now_q <= now_q + 32'd1;
              p_q   <= '0;
              state_q <= S_PCHK;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_FRM: begin
          left_q <= diff;
          if (map_rd_q == 3'd0 || 32'(map_rd_q) > NUM_POOLS) begin
            out_q <= '{OUT_FWD, 2'd0, r_q.can_id, r_q.dlc, r_q.payload,
                       32'd0, 1'b0, 1'b1};
            state_q <= S_IDLE;
          end else if (32'(fill_q[mp]) >= POOL_DEPTH) begin
            out_q <= '{OUT_DROP, 2'(mp), r_q.can_id, r_q.dlc, r_q.payload,
                       32'd0, 1'b0, 1'b1};
            state_q <= S_IDLE;
          end else begin
            state_q <= S_STO;
          end
        end
        S_STO: begin
          if (fill_q[mp] == '0 || 32'(hold_rd_q) < left_q)
            dl_q[mp] <= now_q + 32'(hold_rd_q);
          fill_q[mp] <= fill_q[mp] + 1'b1;
          state_q <= S_IDLE;
        end
        S_PCHK: begin
          if (due_pool) begin
            i_q <= '0;
            state_q <= S_SRD;
          end else state_q <= S_TNXT;
        end
        S_SRD: state_q <= S_SOUT;  // slot read latency
        S_SOUT: begin
          if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_q <= pend_q;
            end
            pend_q <= '{OUT_REL, 2'(p_q), sid_q, sdlc_q, sdat_q, diff,
                        (32'(i_q) + 1 == 32'(cnt)), 1'b0};
            pend_v_q <= 1'b1;
            if (32'(i_q) + 1 == 32'(cnt)) begin
              fill_q[p_q] <= '0;
              state_q <= S_TNXT;
            end else begin
              i_q <= i_q + 1'b1;
              state_q <= S_SRD;
            end
          end
        end
        S_TNXT: begin
          if (last_pool) begin
            if (pend_v_q) begin
              if (out_free) begin
                out_q <= res_t'({pend_q[$bits(res_t)-1:1], 1'b1});
                pend_v_q <= 1'b0;
                state_q <= S_IDLE;
              end
            end else state_q <= S_IDLE;
          end else begin
            p_q <= p_q + 1'b1;
            state_q <= S_PCHK;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CFPA_ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, req.ready |-> !out_v_q)
  `CFPA_ASSERT_NEXT(a_acc_busy, clk_i, rst_ni, req.valid && req.ready, !req.ready)
  `CFPA_ASSERT_IMPL(a_end_rel, clk_i, rst_ni,
    (res.valid && res.data.pool_end) |-> (res.data.out_kind == OUT_REL))
endmodule
`default_nettype wire

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// CAN frame pool accumulator testbench
// Sends frames, ticks and ID table writes through the request channel. A
// behavioral model of the pools predicts every result, and each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cfpa_pkg::*;

  localparam int NPOOL = 4;
  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;

  cfpa_if #(.T(req_t)) req_ch ();
  cfpa_if #(.T(res_t)) res_ch ();

  can_frame_pool_accumulator_top #(
    .NUM_POOLS (NPOOL),
    .POOL_DEPTH(DEPTH),
    .ID_BITS   (11)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_ch.sink),
    .res   (res_ch.source)
  );

  // Model state of the gateway: ID table, time counter and pooled frames.
  // Hold-ups are only read for IDs that have been mapped, and pool slots
  // only below the fill level, so no unwritten entry is ever consulted.
  logic [2:0]  map_pool_tbl [2048];
  logic [15:0] holdup_tbl   [2048];
  logic [31:0] tick_now;
  logic [31:0] deadline     [NPOOL];
  int          fill         [NPOOL];
  logic [10:0] held_id      [NPOOL][DEPTH];
  logic [3:0]  held_dlc     [NPOOL][DEPTH];
  logic [63:0] held_data    [NPOOL][DEPTH];
  logic [31:0] held_arrival [NPOOL][DEPTH];

  res_t pending_results[$];
  int   failures;
  int   cycles;
  bit   idle_free;      // when set, neither side inserts idle cycles

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Cycle watchdog. The slowest run includes the map clearing pass over all
  // 2048 IDs after reset, and a few hundred items each taking at most a full
  // 64-frame flush with stalls on both sides, so this limit is generous.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Append one expected result behind the ones already waiting.
  task automatic queue_result(input res_t e);
    pending_results = {pending_results, e};
  endtask

  // Apply one accepted request to the model and queue what it must produce.
  task automatic predict_pools(input req_t r);
    res_t e;
    logic [2:0] pc;
    int p;
    int n;
    logic [31:0] left;
    logic [31:0] age;
    n = 0;
    e = '0;
    if (r.kind == KIND_FRAME) begin
      pc = map_pool_tbl[r.can_id];
      e.frame_id   = r.can_id;
      e.frame_dlc  = r.dlc;
      e.frame_data = r.payload;
      e.last       = 1'b1;
      if (pc == 3'd0 || pc > NPOOL) begin
        e.out_kind = OUT_FWD;
        queue_result(e);
      end else begin
        p = pc - 1;
        if (fill[p] >= DEPTH) begin
          e.out_kind   = OUT_DROP;
          e.pool_index = p[1:0];
          queue_result(e);
        end else begin
          left = deadline[p] - tick_now;
          if (fill[p] == 0 || {16'd0, holdup_tbl[r.can_id]} < left)
            deadline[p] = tick_now + {16'd0, holdup_tbl[r.can_id]};
          held_id[p][fill[p]]      = r.can_id;
          held_dlc[p][fill[p]]     = r.dlc;
          held_data[p][fill[p]]    = r.payload;
          held_arrival[p][fill[p]] = tick_now;
          fill[p]++;
        end
      end
    end else if (r.kind == KIND_TICK) begin
      tick_now = tick_now + 1;
      for (int q = 0; q < NPOOL; q++) begin
        // A deadline is reached when now minus deadline is not negative
        // in 32-bit two's complement, which tolerates wrap of the counter.
        age = tick_now - deadline[q];
        if (fill[q] != 0 && !age[31]) begin
          for (int i = 0; i < fill[q]; i++) begin
            e = '0;
            e.out_kind   = OUT_REL;
            e.pool_index = q[1:0];
            e.frame_id   = held_id[q][i];
            e.frame_dlc  = held_dlc[q][i];
            e.frame_data = held_data[q][i];
            e.wait_ticks = tick_now - held_arrival[q][i];
            e.pool_end   = (i == fill[q] - 1);
            queue_result(e);
            n++;
          end
          fill[q] = 0;
        end
      end
      if (n > 0) pending_results[$].last = 1'b1;
    end else if (r.kind == KIND_WRITE) begin
      map_pool_tbl[r.can_id] = (r.map_pool > NPOOL) ? 3'd0 : r.map_pool;
      holdup_tbl[r.can_id]   = r.map_holdup;
    end
    // The unused kind is ignored by the block and by the model alike.
  endtask

  // Send one request: random idle cycles first, then hold valid until
  // accepted. Valid stays high across back-to-back requests.
  task automatic send_request(input req_t r);
    if (!idle_free) begin
      while ($urandom_range(99) < 38) begin
        req_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    predict_pools(r);
  endtask

  // Wait until every predicted result has come, then a little longer so
  // that a late unexpected result would still be seen.
  task automatic drain;
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic req_t make_frame(input logic [10:0] id);
    req_t r;
    r = '0;
    r.kind    = KIND_FRAME;
    r.can_id  = id;
    r.dlc     = 4'($urandom_range(8));
    r.payload = {$urandom, $urandom};
    r.map_pool   = 3'($urandom);
    r.map_holdup = 16'($urandom);
    return r;
  endfunction

  function automatic req_t make_tick;
    req_t r;
    r = make_frame(11'($urandom));
    r.kind = KIND_TICK;
    return r;
  endfunction

  function automatic req_t make_write(input logic [10:0] id, input logic [2:0] pc,
                                      input logic [15:0] hold);
    req_t r;
    r = make_frame(11'($urandom));
    r.kind       = KIND_WRITE;
    r.can_id     = id;
    r.map_pool   = pc;
    r.map_holdup = hold;
    return r;
  endfunction

  // Result side: random stalls, and a field-by-field comparison of every
  // accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= idle_free || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk_i) begin
    res_t exp_r;
    res_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = res_ch.data;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        failures++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.out_kind !== exp_r.out_kind ||
            got.pool_index !== exp_r.pool_index ||
            got.frame_id !== exp_r.frame_id ||
            got.frame_dlc !== exp_r.frame_dlc ||
            got.frame_data !== exp_r.frame_data ||
            got.wait_ticks !== exp_r.wait_ticks ||
            got.pool_end !== exp_r.pool_end ||
            got.last !== exp_r.last) begin
          $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
          failures++;
        end
      end
    end
  end

  // Directed: unmapped forwarding with field extremes, the unused kind,
  // a pool code too large, and a minimal hold-up that flushes on one tick.
  task automatic test_forwarding;
    req_t r;
    r = make_frame(11'h7FF);
    r.dlc = 4'd8;
    r.payload = '1;
    send_request(r);
    r = make_frame(11'h000);
    r.dlc = 4'd0;
    r.payload = '0;
    send_request(r);
    r = make_tick();
    r.kind = 2'd3;
    send_request(r);
    send_request(make_write(11'h123, 3'd7, 16'hFFFF));
    send_request(make_frame(11'h123));
    send_request(make_write(11'h7FF, 3'd1, 16'd0));
    send_request(make_frame(11'h7FF));
    send_request(make_tick());
    drain();
  endtask

  // Directed: a pool filled beyond its depth drops and flags, a frame of a
  // shorter hold-up ID meets the full pool, and two pools flush on separate ticks.
  task automatic test_full_pool;
    send_request(make_write(11'h010, 3'd2, 16'd3));
    send_request(make_write(11'h011, 3'd2, 16'd1));
    send_request(make_write(11'h020, 3'd4, 16'd2));
    for (int i = 0; i < DEPTH + 2; i++) send_request(make_frame(11'h010));
    send_request(make_frame(11'h020));
    send_request(make_tick());
    send_request(make_frame(11'h020));
    send_request(make_frame(11'h011));
    send_request(make_tick());
    send_request(make_tick());
    send_request(make_tick());
    drain();
  endtask

  // Random traffic over a small set of IDs so that pools fill and flush,
  // with table rewrites between phases and a stretch without idling.
  task automatic test_random_traffic;
    logic [10:0] ids [8];
    int sel;
    for (int i = 0; i < 8; i++) ids[i] = 11'($urandom);
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 8; i++)
        send_request(make_write(ids[i], 3'($urandom_range(5)),
                                16'((phase == 3) ? 16'hFFFF : $urandom_range(6))));
      idle_free = (phase == 2);
      for (int k = 0; k < 45; k++) begin
        sel = $urandom_range(99);
        if (sel < 55) send_request(make_frame(ids[$urandom_range(7)]));
        else if (sel < 62) send_request(make_frame(11'($urandom)));
        else if (sel < 97) send_request(make_tick());
        else send_request(make_write(ids[$urandom_range(7)], 3'($urandom_range(7)),
                                     16'($urandom_range(6))));
      end
      // Let every pool run out so the next phase starts from empty pools.
      if (phase != 3) for (int t = 0; t < 8; t++) send_request(make_tick());
      idle_free = 1'b0;
      drain();
    end
  endtask

  initial begin
    failures = 0;
    cycles = 0;
    idle_free = 1'b0;
    tick_now = '0;
    for (int i = 0; i < 2048; i++) map_pool_tbl[i] = 3'd0;
    for (int p = 0; p < NPOOL; p++) begin
      fill[p] = 0;
      deadline[p] = '0;
    end
    rst_ni = 1'b0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_forwarding();
    test_full_pool();
    test_random_traffic();
    drain();
    if (failures == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl
rtl/cfpa_pkg.sv
rtl/cfpa_if.sv
rtl/cfpa_deadline.sv
rtl/can_frame_pool_accumulator_top.sv
bench/testbench.sv
